FILE: design/first_fit_block_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define FFBA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FFBA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants and types of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int unsigned MAX_BLOCKS_DEF = 16;
    localparam int unsigned ADDR_BITS_DEF  = 16;
    localparam int unsigned DATA_W         = 16;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EXCEEDS  = 3'd1;
    localparam logic [2:0] ST_NOFIT    = 3'd2;
    localparam logic [2:0] ST_DUP      = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic set;
        logic clr;
    } valid_op_t;

endpackage

FILE: design/ffba_table.sv
// ----------------------------------------------------------------------------
// ffba_table
// Block table: tag, start and end in a synchronous memory, valid bits in flops.
// ----------------------------------------------------------------------------
module ffba_table #(
    parameter int unsigned MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned ADDR_BITS  = ffba_pkg::ADDR_BITS_DEF,
    localparam int unsigned IW = $clog2(MAX_BLOCKS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [IW-1:0]                 rd_idx,
    output logic [ffba_pkg::DATA_W-1:0]   rd_tag,
    output logic [ADDR_BITS-1:0]          rd_start,
    output logic [ADDR_BITS-1:0]          rd_end,
    input  logic                          wr_en,
    input  logic [IW-1:0]                 op_idx,
    input  logic [ffba_pkg::DATA_W-1:0]   wr_tag,
    input  logic [ADDR_BITS-1:0]          wr_start,
    input  logic [ADDR_BITS-1:0]          wr_end,
    input  ffba_pkg::valid_op_t           vop,
    output logic [MAX_BLOCKS-1:0]         valid_vec
);

    localparam int unsigned TW = ffba_pkg::DATA_W + 2 * ADDR_BITS;

    logic [TW-1:0]         mem [MAX_BLOCKS];
    logic [TW-1:0]         rd_word_reg;
    logic [MAX_BLOCKS-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[op_idx] <= {wr_tag, wr_start, wr_end};
        end
        rd_word_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (vop.set)
        begin
            valid_reg[op_idx] <= 1'b1;
        end
        else if (vop.clr)
        begin
            valid_reg[op_idx] <= 1'b0;
        end
    end

    assign rd_tag    = rd_word_reg[TW-1 -: ffba_pkg::DATA_W];
    assign rd_start  = rd_word_reg[2*ADDR_BITS-1 -: ADDR_BITS];
    assign rd_end    = rd_word_reg[ADDR_BITS-1:0];
    assign valid_vec = valid_reg;

endmodule

FILE: design/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a table of blocks held in a synchronous memory.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Payload
//  input    in   in_valid/in_stall  cmd, block_tag, request_size
//  result   out  out_valid/out_stall status, placed_start, placed_end, free_total
//  config   in   cfg_we             cfg_data (region size)
//
// One item at a time. A lookup pass reads the table one entry per cycle.
// An allocate then runs one placement pass per candidate address, up to
// MAX_BLOCKS passes. An allocate over the free total skips the passes and
// goes straight to the result state. No clearing pass after reset; valid
// bits reset at once. Results wait in an output register while the next
// item is taken.
module first_fit_block_allocator #(
    parameter int unsigned MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned ADDR_BITS  = ffba_pkg::ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [15:0] block_tag,
    input  logic [15:0] request_size,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] placed_start,
    output logic [15:0] placed_end,
    output logic [15:0] free_total
);

`include "first_fit_block_allocator_assert.svh"

    localparam int unsigned IW = $clog2(MAX_BLOCKS);
    localparam int unsigned AW = ADDR_BITS;
    localparam int unsigned SW = ((AW > 16) ? AW : 16) + 1;
    localparam logic [IW:0]   CNT_END = (IW+1)'(MAX_BLOCKS);
    localparam logic [IW-1:0] LAST    = IW'(MAX_BLOCKS - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIT, S_RESP} state_t;

    state_t          state_reg;
    logic [IW:0]     cnt_reg;
    logic            chk_vld_reg;
    logic [IW-1:0]   chk_idx_reg;
    logic            cmd_reg;
    logic [15:0]     tag_reg;
    logic [15:0]     size_reg;
    logic [15:0]     region_reg;
    logic [15:0]     remaining_reg;
    logic            dup_reg, slot_found_reg, any_reg, hit_reg;
    logic [IW-1:0]   slot_reg, hit_idx_reg;
    logic [AW-1:0]   hit_start_reg, hit_end_reg;
    logic            conflict_reg, nxt_found_reg;
    logic [AW-1:0]   nxt_reg, cand_reg;
    logic [2:0]      res_status_reg;
    logic [15:0]     res_start_reg, res_end_reg;
    logic            out_valid_reg;
    logic [2:0]      status_reg;
    logic [15:0]     placed_start_reg, placed_end_reg, free_total_reg;

    logic            dup_next, slot_found_next, any_next, hit_next;
    logic [IW-1:0]   slot_next, hit_idx_next;
    logic [AW-1:0]   hit_start_next, hit_end_next;
    logic            conflict_next, nxt_found_next;
    logic [AW-1:0]   nxt_next;

    logic [15:0]           rd_tag;
    logic [AW-1:0]         rd_start, rd_end;
    logic [MAX_BLOCKS-1:0] valid_vec;
    logic                  ent_v, pass_end, issuing, fit_ok, free_ok, wr_en;
    logic [SW-1:0]         hi, free_sum;
    logic [AW-1:0]         free_len;
    logic [IW-1:0]         op_idx;
    ffba_pkg::valid_op_t   vop;

    ffba_table #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_idx    (cnt_reg[IW-1:0]),
        .rd_tag    (rd_tag),
        .rd_start  (rd_start),
        .rd_end    (rd_end),
        .wr_en     (wr_en),
        .op_idx    (op_idx),
        .wr_tag    (tag_reg),
        .wr_start  (cand_reg),
        .wr_end    (AW'(hi)),
        .vop       (vop),
        .valid_vec (valid_vec)
    );

    assign ent_v    = valid_vec[chk_idx_reg];
    assign pass_end = chk_vld_reg && (chk_idx_reg == LAST);
    assign issuing  = ((state_reg == S_SCAN) || (state_reg == S_FIT)) && (cnt_reg < CNT_END);
    assign hi       = SW'(cand_reg) + SW'(size_reg);

    // Fold the entry that just came out of memory into the pass results.
    always_comb
    begin
        dup_next        = dup_reg;
        slot_found_next = slot_found_reg;
        slot_next       = slot_reg;
        any_next        = any_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_start_next  = hit_start_reg;
        hit_end_next    = hit_end_reg;
        conflict_next   = conflict_reg;
        nxt_found_next  = nxt_found_reg;
        nxt_next        = nxt_reg;
        if (chk_vld_reg && (state_reg == S_SCAN))
        begin
            if (ent_v)
            begin
                any_next = 1'b1;
                if ((rd_tag == tag_reg) && !hit_reg)
                begin
                    dup_next       = 1'b1;
                    hit_next       = 1'b1;
                    hit_idx_next   = chk_idx_reg;
                    hit_start_next = rd_start;
                    hit_end_next   = rd_end;
                end
            end
            else if (!slot_found_reg)
            begin
                slot_found_next = 1'b1;
                slot_next       = chk_idx_reg;
            end
        end
        else if (chk_vld_reg && (state_reg == S_FIT) && ent_v)
        begin
            if ((SW'(rd_start) < hi) && (cand_reg < rd_end))
            begin
                conflict_next = 1'b1;
            end
            // Candidates are visited in rising order: track the next block end.
            if ((rd_end > cand_reg) && (!nxt_found_reg || (rd_end < nxt_reg)))
            begin
                nxt_found_next = 1'b1;
                nxt_next       = rd_end;
            end
        end
    end

    assign fit_ok   = !conflict_next && (hi <= SW'(region_reg));
    assign free_ok  = (cmd_reg == ffba_pkg::CMD_FREE) && any_next && hit_next;
    assign free_len = (hit_end_next > hit_start_next) ? (hit_end_next - hit_start_next) : '0;
    assign free_sum = SW'(remaining_reg) + SW'(free_len);

    assign wr_en   = (state_reg == S_FIT) && pass_end && fit_ok;
    assign vop.set = wr_en;
    assign vop.clr = (state_reg == S_SCAN) && pass_end && free_ok;
    assign op_idx  = wr_en ? slot_reg : hit_idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            chk_vld_reg    <= 1'b0;
            region_reg     <= 16'hFFFF;
            remaining_reg  <= 16'hFFFF;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            chk_vld_reg <= issuing;
            chk_idx_reg <= cnt_reg[IW-1:0];
            if (issuing)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                region_reg    <= cfg_data;
                remaining_reg <= cfg_data;
            end

            dup_reg        <= dup_next;
            slot_found_reg <= slot_found_next;
            slot_reg       <= slot_next;
            any_reg        <= any_next;
            hit_reg        <= hit_next;
            hit_idx_reg    <= hit_idx_next;
            hit_start_reg  <= hit_start_next;
            hit_end_reg    <= hit_end_next;
            conflict_reg   <= conflict_next;
            nxt_found_reg  <= nxt_found_next;
            nxt_reg        <= nxt_next;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg        <= cmd;
                        tag_reg        <= block_tag;
                        size_reg       <= request_size;
                        res_start_reg  <= '0;
                        res_end_reg    <= '0;
                        dup_reg        <= 1'b0;
                        slot_found_reg <= 1'b0;
                        any_reg        <= 1'b0;
                        hit_reg        <= 1'b0;
                        cnt_reg        <= '0;
                        if ((cmd == ffba_pkg::CMD_ALLOC) && (request_size > remaining_reg))
                        begin
                            res_status_reg <= ffba_pkg::ST_EXCEEDS;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (pass_end)
                    begin
                        if (cmd_reg == ffba_pkg::CMD_ALLOC)
                        begin
                            if (dup_next)
                            begin
                                res_status_reg <= ffba_pkg::ST_DUP;
                                state_reg      <= S_RESP;
                            end
                            else if (!slot_found_next)
                            begin
                                res_status_reg <= ffba_pkg::ST_FULL;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                cand_reg      <= '0;
                                conflict_reg  <= 1'b0;
                                nxt_found_reg <= 1'b0;
                                cnt_reg       <= '0;
                                state_reg     <= S_FIT;
                            end
                        end
                        else if (!any_next)
                        begin
                            res_status_reg <= ffba_pkg::ST_EMPTY;
                            state_reg      <= S_RESP;
                        end
                        else if (!hit_next)
                        begin
                            res_status_reg <= ffba_pkg::ST_NOTFOUND;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            res_status_reg <= ffba_pkg::ST_OK;
                            remaining_reg  <= (free_sum > SW'(16'hFFFF)) ? 16'hFFFF
                                                                         : free_sum[15:0];
                            state_reg      <= S_RESP;
                        end
                    end
                end
                S_FIT:
                begin
                    if (pass_end)
                    begin
                        if (fit_ok)
                        begin
                            res_status_reg <= ffba_pkg::ST_OK;
                            res_start_reg  <= 16'(cand_reg);
                            res_end_reg    <= 16'(AW'(hi));
                            remaining_reg  <= remaining_reg - size_reg;
                            state_reg      <= S_RESP;
                        end
                        else if (nxt_found_next)
                        begin
                            cand_reg      <= nxt_next;
                            conflict_reg  <= 1'b0;
                            nxt_found_reg <= 1'b0;
                            cnt_reg       <= '0;
                        end
                        else
                        begin
                            res_status_reg <= ffba_pkg::ST_NOFIT;
                            state_reg      <= S_RESP;
                        end
                    end
                end
                S_RESP:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg    <= 1'b1;
                        status_reg       <= res_status_reg;
                        placed_start_reg <= res_start_reg;
                        placed_end_reg   <= res_end_reg;
                        free_total_reg   <= remaining_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign placed_start = placed_start_reg;
    assign placed_end   = placed_end_reg;
    assign free_total   = free_total_reg;

    `FFBA_ASSERT_IMP(a_err_no_place, out_valid && (status != ffba_pkg::ST_OK),
        (placed_start == 16'd0) && (placed_end == 16'd0), "error result carries a placement")
    `FFBA_ASSERT_IMP(a_chk_in_pass, chk_vld_reg,
        (state_reg == S_SCAN) || (state_reg == S_FIT), "table read outside a pass")
    `FFBA_ASSERT_IMP(a_cand_rises, (state_reg == S_FIT) && $past(state_reg == S_FIT),
        cand_reg >= $past(cand_reg), "placement candidate moved down")
    `FFBA_ASSERT_NXT(a_single_write, wr_en, !$past(vop.clr), "table set and clear together")

endmodule
